FILE: rtl/nps_pkg.sv
`timescale 1ns / 1ps
package nps_pkg;

	localparam int MAX_RESIDUES_DEF = 64;
	localparam int COORD_W = 21;
	localparam int PT_W = 3 * COORD_W;
	localparam int WORD_W = PT_W + 1;
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int D2_W = 44;
	localparam int ROOT_W = 22;
	localparam int PIDX_W = 7;
	localparam logic [ROOT_W-1:0] DIST_NONE = '1;
	localparam logic signed [PIDX_W-1:0] INDEX_NONE = '1;

	typedef struct packed {
		logic clear;
		logic issue;
	} dist_ctrl_t;

	typedef struct packed {
		logic busy;
		logic found;
	} dist_stat_t;

endpackage

FILE: rtl/nps_in_if.sv
`timescale 1ns / 1ps
interface nps_in_if;
	logic valid;
	logic ready;
	logic signed [20:0] ref_x;
	logic signed [20:0] ref_y;
	logic signed [20:0] ref_z;
	logic signed [20:0] anchor_x;
	logic signed [20:0] anchor_y;
	logic signed [20:0] anchor_z;
	logic valid_in;
	logic last_in;
	modport source (output valid, ref_x, ref_y, ref_z, anchor_x, anchor_y, anchor_z,
		valid_in, last_in, input ready);
	modport sink (input valid, ref_x, ref_y, ref_z, anchor_x, anchor_y, anchor_z,
		valid_in, last_in, output ready);
endinterface

FILE: rtl/nps_out_if.sv
`timescale 1ns / 1ps
interface nps_out_if;
	logic valid;
	logic ready;
	logic signed [6:0] partner_index;
	logic [21:0] distance;
	logic has_partner;
	logic last_out;
	modport source (output valid, partner_index, distance, has_partner, last_out,
		input ready);
	modport sink (input valid, partner_index, distance, has_partner, last_out,
		output ready);
endinterface

FILE: rtl/nps_ram.sv
`timescale 1ns / 1ps
module nps_ram #(
	parameter int DEPTH = nps_pkg::MAX_RESIDUES_DEF,
	parameter int WIDTH = nps_pkg::WORD_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule

FILE: rtl/nps_dist.sv
`timescale 1ns / 1ps
module nps_dist #(
	parameter int AW = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nps_pkg::dist_ctrl_t     ctrl,
	input  logic [AW-1:0]           j,
	input  logic [nps_pkg::PT_W-1:0]   ref_pt,
	input  logic [nps_pkg::WORD_W-1:0] anchor_word,
	output nps_pkg::dist_stat_t     stat,
	output logic [AW-1:0]           best_j_q,
	output logic [nps_pkg::D2_W-1:0] best_q
);
	import nps_pkg::*;

	logic valid_s0, valid_s1, valid_s2, valid_s3;
	logic [AW-1:0] j_s0, j_s1, j_s2, j_s3;
	logic [DIFF_W-1:0] mag_s1 [3];
	logic [SQ_W-1:0] sq_s2 [3];
	logic [D2_W-1:0] sum_s3;
	logic found_q;
	logic [DIFF_W-1:0] mag [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [DIFF_W-1:0] d;
			d = DIFF_W'($signed(ref_pt[k*COORD_W +: COORD_W]))
				- DIFF_W'($signed(anchor_word[k*COORD_W +: COORD_W]));
			mag[k] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			valid_s0 <= ctrl.issue;
			valid_s1 <= valid_s0 & anchor_word[WORD_W-1];
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (ctrl.clear) begin
				found_q <= 1'b0;
			end else if (valid_s3) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		j_s0 <= j;
		j_s1 <= j_s0;
		j_s2 <= j_s1;
		j_s3 <= j_s2;
		for (int k = 0; k < 3; k++) begin
			mag_s1[k] <= mag[k];
			sq_s2[k]  <= mag_s1[k] * mag_s1[k];
		end
		sum_s3 <= D2_W'(sq_s2[0]) + D2_W'(sq_s2[1]) + D2_W'(sq_s2[2]);
		// strict less keeps the lowest index on ties
		if (valid_s3 && !ctrl.clear && (!found_q || sum_s3 < best_q)) begin
			best_q   <= sum_s3;
			best_j_q <= j_s3;
		end
	end

	assign stat.busy  = valid_s0 | valid_s1 | valid_s2 | valid_s3;
	assign stat.found = found_q;
endmodule

FILE: rtl/nps_isqrt.sv
`timescale 1ns / 1ps
module nps_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nps_pkg::D2_W-1:0]  value,
	output logic                      done_q,
	output logic [nps_pkg::ROOT_W-1:0] root
);
	import nps_pkg::*;

	logic busy_q;
	logic [D2_W-1:0] v_q, r_q, bit_q, trial;

	assign trial = r_q + bit_q;
	assign root  = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q & bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one result bit per cycle, highest even power first
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= D2_W'(1) << (D2_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

FILE: rtl/nearest_partner_search_unit.sv
`timescale 1ns / 1ps
// Nearest partner search over a set of residues.
// req carries one residue per transaction: reference point, anchor point,
// valid flag and last flag. Residues are written to two on-chip RAMs while
// req.ready is high, one per cycle. The transaction with last_in set, or the
// one filling the final entry, closes the set and starts the search; req.ready
// then stays low until the last result of the set has entered the output register.
// rsp returns one transaction per residue, in index order, last_out on
// the final one. A searched residue reads its reference point, streams the
// candidate indices 1..N-2 from the anchor RAM, one per cycle, drains the
// distance pipeline, runs the bit-serial square root and loads the output
// register; a residue that is not searched streams no candidates.
// The output register holds a result while rsp.ready is low; the search of
// the next residue stops until that register frees.
// Reset clears the control state and the fill count; the RAMs need no
// clearing as only entries of the current set are read.
module nearest_partner_search_unit #(
	parameter int MAX_RESIDUES = nps_pkg::MAX_RESIDUES_DEF
) (
	input logic clk,
	input logic arst_n,
	nps_in_if.sink    req,
	nps_out_if.source rsp
);
	import nps_pkg::*;

	localparam int AW = $clog2(MAX_RESIDUES);
	localparam int CW = $clog2(MAX_RESIDUES + 1);

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_RDREF = 6'b000010,
		S_SWEEP = 6'b000100,
		S_DRAIN = 6'b001000,
		S_SQRT  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, n_q;
	logic [AW-1:0] i_q, j_q;
	logic accept, close_set, eligible, last_j, last_i, out_take, sq_start, sq_done;
	logic [WORD_W-1:0] ref_word, anchor_word, ref_wdata, anchor_wdata;
	logic [ROOT_W-1:0] root;
	logic [AW-1:0] best_j;
	logic [D2_W-1:0] best_d2;
	dist_ctrl_t dctrl;
	dist_stat_t dstat;

	assign req.ready = (state_q == S_LOAD);
	assign accept    = req.valid & req.ready;
	assign close_set = req.last_in | (count_q == CW'(MAX_RESIDUES - 1));
	assign ref_wdata    = {req.valid_in, req.ref_z, req.ref_y, req.ref_x};
	assign anchor_wdata = {req.valid_in, req.anchor_z, req.anchor_y, req.anchor_x};

	nps_ram #(.DEPTH(MAX_RESIDUES), .WIDTH(WORD_W)) u_ref_ram (
		.clk(clk), .we(accept), .waddr(count_q[AW-1:0]), .wdata(ref_wdata),
		.raddr(i_q), .rdata_q(ref_word)
	);

	nps_ram #(.DEPTH(MAX_RESIDUES), .WIDTH(WORD_W)) u_anchor_ram (
		.clk(clk), .we(accept), .waddr(count_q[AW-1:0]), .wdata(anchor_wdata),
		.raddr(j_q), .rdata_q(anchor_word)
	);

	assign eligible = ref_word[WORD_W-1] && (i_q != '0) && (CW'(i_q) + CW'(1) < n_q);
	assign last_j   = (CW'(j_q) + CW'(2) == n_q);
	assign last_i   = (CW'(i_q) + CW'(1) == n_q);
	assign dctrl.clear = (state_q == S_RDREF);
	assign dctrl.issue = (state_q == S_SWEEP) && eligible && (j_q != i_q);
	assign sq_start    = (state_q == S_DRAIN) && !dstat.busy;
	assign out_take    = (state_q == S_OUT) && (!rsp.valid || rsp.ready);

	nps_dist #(.AW(AW)) u_dist (
		.clk(clk), .arst_n(arst_n), .ctrl(dctrl), .j(j_q),
		.ref_pt(ref_word[PT_W-1:0]), .anchor_word(anchor_word),
		.stat(dstat), .best_j_q(best_j), .best_q(best_d2)
	);

	nps_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(best_d2),
		.done_q(sq_done), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (close_set) begin
							n_q     <= count_q + CW'(1);
							count_q <= '0;
							i_q     <= '0;
							state_q <= S_RDREF;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_RDREF: begin
					j_q     <= AW'(1);
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (!eligible || last_j) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				S_DRAIN: begin
					if (!dstat.busy) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_take) begin
						if (last_i) begin
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_RDREF;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (out_take) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			rsp.has_partner   <= dstat.found;
			rsp.last_out      <= last_i;
			rsp.partner_index <= dstat.found ? PIDX_W'(best_j) : INDEX_NONE;
			rsp.distance      <= dstat.found ? root : DIST_NONE;
		end
	end

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (count_q < CW'(MAX_RESIDUES)))
		else $error("fill count beyond store depth");
	a_issue_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		dctrl.issue |-> (CW'(j_q) + CW'(1) < n_q) && (j_q != '0))
		else $error("candidate outside interior of set");
	a_sqrt_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !dctrl.issue && !dstat.busy)
		else $error("square root started with candidates in flight");
	a_found_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && dstat.found |-> ref_word[WORD_W-1] && (i_q != '0))
		else $error("partner reported for ineligible residue");
endmodule
